// ----- hw/rtl/arqsw_pkg.sv -----
package arqsw_pkg;

  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned SEQ_W    = 24;
  localparam int unsigned HANDLE_W = 16;
  localparam int unsigned KIND_W   = 8;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned RETRY_W  = 8;
  localparam int unsigned CNT_W    = 6;
  localparam int unsigned RES_W    = 3;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned REG_SEL_BIT = 2;

  localparam int unsigned WINDOW_DEPTH_DEF = 32;
  localparam int unsigned RETX_BURST_DEF   = 16;
  localparam int unsigned QUEUE_DEPTH      = 2;

  localparam logic [SEQ_W-1:0]   HALF_SEQ        = 24'h800000;
  localparam logic [RETRY_W-1:0] RETRY_MAX       = 8'hFF;
  localparam logic [TIME_W-1:0]  TIMEOUT_RST     = 32'd1000;
  localparam logic [RETRY_W-1:0] RETRY_LIMIT_RST = 8'd5;

  localparam logic REG_TIMEOUT = 1'b0;
  localparam logic REG_RETRY   = 1'b1;

  typedef enum logic [FUNC_W-1:0] {
    OP_SEND = 2'd0,
    OP_ACK  = 2'd1,
    OP_NACK = 2'd2,
    OP_TICK = 2'd3
  } op_e;

  typedef enum logic [RES_W-1:0] {
    RES_ACCEPTED = 3'd0,
    RES_FULL     = 3'd1,
    RES_RELEASED = 3'd2,
    RES_RETX     = 3'd3,
    RES_DROPPED  = 3'd4,
    RES_SUMMARY  = 3'd5
  } res_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_SUM
  } st_e;

  typedef struct packed {
    op_e                 op;
    logic [SEQ_W-1:0]    seq;
    logic [HANDLE_W-1:0] handle;
    logic [KIND_W-1:0]   kind;
    logic [TIME_W-1:0]   now;
  } item_t;

  typedef struct packed {
    logic [SEQ_W-1:0]    seq;
    logic [HANDLE_W-1:0] handle;
    logic [KIND_W-1:0]   kind;
    logic [TIME_W-1:0]   sent_at;
    logic [RETRY_W-1:0]  retries;
  } slot_t;

  typedef struct packed {
    res_e                result_kind;
    logic [SEQ_W-1:0]    entry_seq;
    logic [HANDLE_W-1:0] entry_handle;
    logic [KIND_W-1:0]   entry_kind;
    logic [CNT_W-1:0]    affected_count;
    logic                last;
  } res_t;

endpackage

// ----- hw/rtl/arqsw_req_if.sv -----
interface arqsw_req_if;
  import arqsw_pkg::*;
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [SEQ_W-1:0]    seq_number;
  logic [HANDLE_W-1:0] buffer_handle;
  logic [KIND_W-1:0]   segment_kind;
  logic [TIME_W-1:0]   time_now;

  modport source (output valid, func, seq_number, buffer_handle, segment_kind, time_now,
                  input ready);
  modport sink (input valid, func, seq_number, buffer_handle, segment_kind, time_now,
                output ready);
endinterface

// ----- hw/rtl/arqsw_rsp_if.sv -----
interface arqsw_rsp_if;
  import arqsw_pkg::*;
  logic                valid;
  logic                ready;
  logic [RES_W-1:0]    result_kind;
  logic [SEQ_W-1:0]    entry_seq;
  logic [HANDLE_W-1:0] entry_handle;
  logic [KIND_W-1:0]   entry_kind;
  logic [CNT_W-1:0]    affected_count;
  logic                last;

  modport source (output valid, result_kind, entry_seq, entry_handle, entry_kind,
                  affected_count, last, input ready);
  modport sink (input valid, result_kind, entry_seq, entry_handle, entry_kind,
                affected_count, last, output ready);
endinterface

// ----- hw/rtl/arqsw_front.sv -----
module arqsw_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  arqsw_req_if.sink       req_i,
  output logic            item_valid_o,
  output arqsw_pkg::item_t item_o,
  input  logic            item_full_i
);
  import arqsw_pkg::*;

  logic  valid_q;
  item_t item_q;
  item_t item_d;
  logic  take;
  logic  push;

  // only a send carries a buffer handle and a segment kind
  always_comb begin
    item_d.op     = op_e'(req_i.func);
    item_d.seq    = req_i.seq_number;
    item_d.now    = req_i.time_now;
    item_d.handle = '0;
    item_d.kind   = '0;
    if (item_d.op == OP_SEND) begin
      item_d.handle = req_i.buffer_handle;
      item_d.kind   = req_i.segment_kind;
    end
  end

  assign push        = valid_q && !item_full_i;
  assign req_i.ready = !valid_q || !item_full_i;
  assign take        = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take) begin
      valid_q <= 1'b1;
    end else if (push) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_d;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;
endmodule

// ----- hw/rtl/arqsw_fifo.sv -----
module arqsw_fifo #(
  parameter int unsigned DEPTH = arqsw_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  arqsw_pkg::item_t data_i,
  output logic             full_o,
  output logic             valid_o,
  output arqsw_pkg::item_t data_o,
  input  logic             pop_i
);
  import arqsw_pkg::*;

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [IW-1:0] IDX_LAST = IW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  item_t         slots_q [DEPTH];
  logic [IW-1:0] wr_q;
  logic [IW-1:0] rd_q;
  logic [CW-1:0] cnt_q;
  logic          push_ok;
  logic          pop_ok;

  assign full_o  = (cnt_q == CNT_FULL);
  assign valid_o = (cnt_q != '0);
  assign data_o  = slots_q[rd_q];
  assign push_ok = push_i && !full_o;
  assign pop_ok  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_ok) begin
        wr_q <= (wr_q == IDX_LAST) ? '0 : wr_q + 1'b1;
      end
      if (pop_ok) begin
        rd_q <= (rd_q == IDX_LAST) ? '0 : rd_q + 1'b1;
      end
      case ({push_ok, pop_ok})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      slots_q[wr_q] <= data_i;
    end
  end
endmodule

// ----- hw/rtl/arqsw_back.sv -----
module arqsw_back #(
  parameter int unsigned WINDOW_DEPTH = arqsw_pkg::WINDOW_DEPTH_DEF,
  parameter int unsigned RETX_BURST   = arqsw_pkg::RETX_BURST_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            item_valid_i,
  input  arqsw_pkg::item_t                item_i,
  output logic                            item_pop_o,
  input  logic [arqsw_pkg::TIME_W-1:0]    timeout_i,
  input  logic [arqsw_pkg::RETRY_W-1:0]   retry_limit_i,
  arqsw_rsp_if.source                     rsp_o
);
  import arqsw_pkg::*;

  localparam int unsigned SW = $clog2(WINDOW_DEPTH);
  localparam int unsigned PW = $clog2(2 * WINDOW_DEPTH);
  localparam int unsigned NW = $clog2(WINDOW_DEPTH + 1);
  localparam logic [PW-1:0]    PTR_LAST = PW'(2 * WINDOW_DEPTH - 1);
  localparam logic [PW-1:0]    DEPTH_P  = PW'(WINDOW_DEPTH);
  localparam logic [PW:0]      SPAN     = (PW + 1)'(2 * WINDOW_DEPTH);
  localparam logic [NW-1:0]    DEPTH_N  = NW'(WINDOW_DEPTH);
  localparam logic [CNT_W-1:0] BURST_C  = CNT_W'(RETX_BURST);

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [SW-1:0] slot_of(input logic [PW-1:0] p);
    logic [PW-1:0] r;
    r = (p >= DEPTH_P) ? p - DEPTH_P : p;
    return r[SW-1:0];
  endfunction

  st_e                 state_q, state_d;
  item_t               op_q;
  logic [PW-1:0]       base_q, next_q, p_q;
  logic [NW-1:0]       i_q, n_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [WINDOW_DEPTH-1:0] busy_q;
  slot_t               mem [WINDOW_DEPTH];
  slot_t               rd_q;
  logic                out_valid_q;
  res_t                out_q;

  logic                out_free;
  logic [SW-1:0]       cur_slot, send_slot, rd_addr, mem_wa;
  logic                busy_cur;
  logic [SEQ_W-1:0]    ack_diff, nack_diff;
  logic [TIME_W-1:0]   age;
  logic                expired, can_retx;
  logic [RETRY_W-1:0]  retries_inc;
  logic                walk_end, walk_emit;
  res_e                walk_kind;
  logic                step;
  logic [PW:0]         occ_raw;
  logic [NW-1:0]       occ;
  logic                send_full;
  logic                idle_go_send, idle_go_walk;
  logic                emit_v, mem_we;
  res_t                emit_r;
  slot_t               mem_wd;

  assign out_free  = !out_valid_q || rsp_o.ready;
  assign cur_slot  = slot_of(p_q);
  assign send_slot = slot_of(next_q);
  assign busy_cur  = busy_q[cur_slot];

  assign ack_diff    = op_q.seq - rd_q.seq;
  assign nack_diff   = rd_q.seq - op_q.seq;
  assign age         = op_q.now - rd_q.sent_at;
  assign expired     = age > timeout_i;
  assign can_retx    = rd_q.retries < retry_limit_i;
  assign retries_inc = (rd_q.retries == RETRY_MAX) ? rd_q.retries : rd_q.retries + 1'b1;

  always_comb begin
    occ_raw = {1'b0, next_q} - {1'b0, base_q};
    if (next_q < base_q) begin
      occ_raw = occ_raw + SPAN;
    end
    occ = NW'(occ_raw);
  end

  assign send_full    = busy_q[send_slot] || (occ >= DEPTH_N);
  assign idle_go_send = (state_q == ST_IDLE) && item_valid_i && (item_i.op == OP_SEND)
                        && out_free;
  assign idle_go_walk = (state_q == ST_IDLE) && item_valid_i && (item_i.op != OP_SEND);
  assign item_pop_o   = idle_go_send || idle_go_walk;

  // per-entry decision on the slot read out last cycle
  always_comb begin
    walk_end  = 1'b1;
    walk_emit = 1'b0;
    walk_kind = RES_RETX;
    unique case (op_q.op)
      OP_ACK: begin
        walk_end  = (p_q == next_q) || (ack_diff >= HALF_SEQ);
        walk_emit = busy_cur;
        walk_kind = RES_RELEASED;
      end
      OP_NACK: begin
        walk_end  = (i_q == n_q) || (cnt_q == BURST_C);
        walk_emit = busy_cur && (nack_diff < HALF_SEQ);
        walk_kind = RES_RETX;
      end
      OP_TICK: begin
        walk_end  = (i_q == n_q);
        walk_emit = busy_cur && expired;
        walk_kind = can_retx ? RES_RETX : RES_DROPPED;
      end
      default: begin
        walk_end = 1'b1;
      end
    endcase
  end

  assign step = (state_q == ST_WALK) && !walk_end && (!walk_emit || out_free);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (idle_go_walk) state_d = ST_WALK;
      ST_WALK: if (walk_end) state_d = ST_SUM;
      ST_SUM:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    emit_v  = 1'b0;
    emit_r  = '0;
    mem_we  = 1'b0;
    mem_wa  = send_slot;
    mem_wd  = rd_q;
    rd_addr = slot_of(base_q);
    unique case (state_q)
      ST_IDLE: begin
        if (idle_go_send) begin
          emit_v              = 1'b1;
          emit_r.result_kind  = send_full ? RES_FULL : RES_ACCEPTED;
          emit_r.entry_seq    = item_i.seq;
          emit_r.entry_handle = item_i.handle;
          emit_r.entry_kind   = item_i.kind;
          emit_r.last         = 1'b1;
          if (!send_full) begin
            mem_we         = 1'b1;
            mem_wd.seq     = item_i.seq;
            mem_wd.handle  = item_i.handle;
            mem_wd.kind    = item_i.kind;
            mem_wd.sent_at = item_i.now;
            mem_wd.retries = '0;
          end
        end
      end
      ST_WALK: begin
        rd_addr = step ? slot_of(ptr_inc(p_q)) : cur_slot;
        if (step && walk_emit) begin
          emit_v              = 1'b1;
          emit_r.result_kind  = walk_kind;
          emit_r.entry_seq    = rd_q.seq;
          emit_r.entry_handle = rd_q.handle;
          emit_r.entry_kind   = rd_q.kind;
          if (walk_kind == RES_RETX) begin
            mem_we         = 1'b1;
            mem_wa         = cur_slot;
            mem_wd.sent_at = op_q.now;
            mem_wd.retries = retries_inc;
          end
        end
      end
      ST_SUM: begin
        if (out_free) begin
          emit_v                = 1'b1;
          emit_r.result_kind    = RES_SUMMARY;
          emit_r.entry_seq      = (op_q.op == OP_TICK) ? '0 : op_q.seq;
          emit_r.affected_count = cnt_q;
          emit_r.last           = 1'b1;
        end
      end
      default: begin
        emit_v = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      base_q      <= '0;
      next_q      <= '0;
      p_q         <= '0;
      i_q         <= '0;
      n_q         <= '0;
      cnt_q       <= '0;
      busy_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (idle_go_send && !send_full) begin
        busy_q[send_slot] <= 1'b1;
        next_q            <= ptr_inc(next_q);
      end
      if (idle_go_walk) begin
        p_q   <= base_q;
        i_q   <= '0;
        cnt_q <= '0;
        n_q   <= occ;
      end
      if (step) begin
        p_q <= ptr_inc(p_q);
        i_q <= i_q + 1'b1;
        if (walk_emit) begin
          cnt_q <= cnt_q + 1'b1;
        end
        if (op_q.op == OP_ACK) begin
          busy_q[cur_slot] <= 1'b0;
          base_q           <= ptr_inc(p_q);
        end else if (walk_emit && (walk_kind == RES_DROPPED)) begin
          busy_q[cur_slot] <= 1'b0;
        end
      end
      if (emit_v) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (idle_go_walk) begin
      op_q <= item_i;
    end
    if (emit_v) begin
      out_q <= emit_r;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q <= mem[rd_addr];
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.result_kind    = out_q.result_kind;
  assign rsp_o.entry_seq      = out_q.entry_seq;
  assign rsp_o.entry_handle   = out_q.entry_handle;
  assign rsp_o.entry_kind     = out_q.entry_kind;
  assign rsp_o.affected_count = out_q.affected_count;
  assign rsp_o.last           = out_q.last;
endmodule

// ----- hw/rtl/arq_send_window.sv -----
// Channel   Dir  Handshake      Beat carries
// req_i     in   valid/ready    func, seq_number, buffer_handle, segment_kind, time_now
// rsp_o     out  valid/ready    result_kind, entry_seq, entry_handle, entry_kind,
//                               affected_count, last
// APB       in   psel/penable   timeout_ticks at 0x0, retry_limit at 0x4
//
// A send gives one beat from the back end.
// Ack, nack and tick walk the window in the back end: a start step, one step per
// entry visited, a step to see the end of the walk and one for the summary.
// The slot memory has one read port and the walk visits one entry per cycle while
// rsp_o is not stalled, reading the next slot while judging this one.
// Reset clears the busy flags and both pointers at once; no clearing pass.
// A stalled rsp_o holds the walk on an entry with a beat to give; req_i keeps filling
// the front register and the two-beat queue meanwhile.
module arq_send_window #(
  parameter int unsigned WINDOW_DEPTH = arqsw_pkg::WINDOW_DEPTH_DEF,
  parameter int unsigned RETX_BURST   = arqsw_pkg::RETX_BURST_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  arqsw_req_if.sink                       req_i,
  arqsw_rsp_if.source                     rsp_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [arqsw_pkg::PADDR_W-1:0]   paddr,
  input  logic [arqsw_pkg::DATA_W-1:0]    pwdata,
  output logic [arqsw_pkg::DATA_W-1:0]    prdata,
  output logic                            pready
);
  import arqsw_pkg::*;

  logic [TIME_W-1:0]  timeout_q;
  logic [RETRY_W-1:0] retry_limit_q;
  logic               cfg_we;
  logic               reg_sel;

  item_t front_item, queue_item;
  logic  front_valid, queue_full, queue_valid, queue_pop;

  // register file: written in the access phase, always ready
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign reg_sel = paddr[REG_SEL_BIT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q     <= TIMEOUT_RST;
      retry_limit_q <= RETRY_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (reg_sel)
        REG_TIMEOUT: timeout_q     <= pwdata;
        REG_RETRY:   retry_limit_q <= pwdata[RETRY_W-1:0];
        default:     timeout_q     <= timeout_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_TIMEOUT: prdata = timeout_q;
      REG_RETRY:   prdata = {{(DATA_W - RETRY_W){1'b0}}, retry_limit_q};
      default:     prdata = '0;
    endcase
  end

  // front: register and classify each beat
  arqsw_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .item_valid_o (front_valid),
    .item_o       (front_item),
    .item_full_i  (queue_full)
  );

  // decouple classification from the window walk
  arqsw_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .data_i  (front_item),
    .full_o  (queue_full),
    .valid_o (queue_valid),
    .data_o  (queue_item),
    .pop_i   (queue_pop)
  );

  // back: window state, slot memory and result register
  arqsw_back #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .RETX_BURST   (RETX_BURST)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (queue_valid),
    .item_i        (queue_item),
    .item_pop_o    (queue_pop),
    .timeout_i     (timeout_q),
    .retry_limit_i (retry_limit_q),
    .rsp_o         (rsp_o)
  );

  // a summary always closes its item
  a_sum_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && (rsp_o.result_kind == RES_SUMMARY) |-> rsp_o.last)
    else $error("summary beat without last");

  // per-entry beats of a walk never close the item
  a_walk_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && ((rsp_o.result_kind == RES_RELEASED) ||
                    (rsp_o.result_kind == RES_RETX) ||
                    (rsp_o.result_kind == RES_DROPPED)) |-> !rsp_o.last)
    else $error("walk beat marked last");

  // only a summary carries a count
  a_count_sum_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && (rsp_o.result_kind != RES_SUMMARY) |-> (rsp_o.affected_count == '0))
    else $error("count outside summary");
endmodule

// ----- dv/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import arqsw_pkg::*;

  localparam int unsigned DEPTH      = WINDOW_DEPTH_DEF;
  localparam int unsigned BURST      = RETX_BURST_DEF;
  localparam int unsigned DRAIN_WAIT = DEPTH + 8;
  localparam int unsigned CYCLE_CAP  = 1000000;
  localparam int unsigned PHASE_LEN  = 30;

  typedef struct {
    item_t it;
    bit    typed;
    res_t  want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0]  pwdata = '0;
  logic [DATA_W-1:0]  prdata;
  logic pready;

  arqsw_req_if req ();
  arqsw_rsp_if rsp ();

  arq_send_window dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req),
    .rsp_o   (rsp),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #4 clk_i = ~clk_i;

  // Shadow of the window: slot contents, busy flags, ring pointers, registers.
  logic [SEQ_W-1:0]    w_seq     [DEPTH];
  logic [HANDLE_W-1:0] w_handle  [DEPTH];
  logic [KIND_W-1:0]   w_kind    [DEPTH];
  logic [TIME_W-1:0]   w_sent    [DEPTH];
  logic [RETRY_W-1:0]  w_retries [DEPTH];
  bit                  w_busy    [DEPTH];
  logic [5:0]          w_base, w_next;
  logic [TIME_W-1:0]   timeout_reg;
  logic [RETRY_W-1:0]  retry_reg;

  res_t pending_results[$];
  int   errors = 0;
  int   beats_in = 0;
  int   beats_checked = 0;
  int   cycles = 0;
  bit   calm = 1'b0;      // no idling on either side while set

  logic [SEQ_W-1:0]  seq_cursor;
  logic [TIME_W-1:0] clock_now;

  function automatic res_t make_res(res_e k, logic [SEQ_W-1:0] s, logic [HANDLE_W-1:0] h,
                                    logic [KIND_W-1:0] kd, logic [CNT_W-1:0] c, logic l);
    res_t r;
    r.result_kind    = k;
    r.entry_seq      = s;
    r.entry_handle   = h;
    r.entry_kind     = kd;
    r.affected_count = c;
    r.last           = l;
    return r;
  endfunction

  function automatic res_t slot_res(res_e k, int s);
    return make_res(k, w_seq[s], w_handle[s], w_kind[s], '0, 1'b0);
  endfunction

  // Compute the beats one request causes and update the shadow window.
  task automatic window_model(input item_t it, output res_t outs[$]);
    logic [5:0] occ;
    int         s;
    int         cnt;
    occ = w_next - w_base;
    cnt = 0;
    outs = {};
    case (it.op)
      OP_SEND: begin
        s = w_next[4:0];
        if (w_busy[s] || occ >= DEPTH) begin
          outs.push_back(make_res(RES_FULL, it.seq, it.handle, it.kind, '0, 1'b1));
        end else begin
          w_seq[s] = it.seq; w_handle[s] = it.handle; w_kind[s] = it.kind;
          w_sent[s] = it.now; w_retries[s] = '0; w_busy[s] = 1'b1;
          w_next = w_next + 6'd1;
          outs.push_back(make_res(RES_ACCEPTED, it.seq, it.handle, it.kind, '0, 1'b1));
        end
      end
      OP_ACK: begin
        while (w_base != w_next) begin
          s = w_base[4:0];
          if (SEQ_W'(it.seq - w_seq[s]) >= HALF_SEQ) break;
          if (w_busy[s]) begin
            outs.push_back(slot_res(RES_RELEASED, s));
            cnt++;
          end
          w_busy[s] = 1'b0;
          w_base = w_base + 6'd1;
        end
        outs.push_back(make_res(RES_SUMMARY, it.seq, '0, '0, CNT_W'(cnt), 1'b1));
      end
      OP_NACK: begin
        // go back N from the nacked number, capped at the burst size
        for (int i = 0; i < occ && cnt < BURST; i++) begin
          s = (w_base + i) % DEPTH;
          if (w_busy[s] && SEQ_W'(w_seq[s] - it.seq) < HALF_SEQ) begin
            w_sent[s] = it.now;
            if (w_retries[s] != RETRY_MAX) w_retries[s]++;
            outs.push_back(slot_res(RES_RETX, s));
            cnt++;
          end
        end
        outs.push_back(make_res(RES_SUMMARY, it.seq, '0, '0, CNT_W'(cnt), 1'b1));
      end
      default: begin
        for (int i = 0; i < occ; i++) begin
          s = (w_base + i) % DEPTH;
          if (w_busy[s] && TIME_W'(it.now - w_sent[s]) > timeout_reg) begin
            if (w_retries[s] < retry_reg) begin
              w_sent[s] = it.now;
              if (w_retries[s] != RETRY_MAX) w_retries[s]++;
              outs.push_back(slot_res(RES_RETX, s));
            end else begin
              w_busy[s] = 1'b0;
              outs.push_back(slot_res(RES_DROPPED, s));
            end
            cnt++;
          end
        end
        outs.push_back(make_res(RES_SUMMARY, '0, '0, '0, CNT_W'(cnt), 1'b1));
      end
    endcase
  endtask

  task automatic report(string field, longint unsigned got, longint unsigned want);
    $display("mismatch at beat %0d: %s got 0x%0h expected 0x%0h",
             beats_checked, field, got, want);
    errors++;
  endtask

  function automatic int draw_gap();
    if (calm || $urandom_range(0, 4) == 0) return 0;
    return $urandom_range(0, 11);
  endfunction

  // Present one request beat and hold it until accepted, then predict it.
  task automatic push_item(input item_t it, input bit typed, input res_t want);
    int   gap;
    res_t outs[$];
    gap = draw_gap();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req.valid         <= 1'b1;
    req.func          <= it.op;
    req.seq_number    <= it.seq;
    req.buffer_handle <= it.handle;
    req.segment_kind  <= it.kind;
    req.time_now      <= it.now;
    do @(posedge clk_i); while (!req.ready);
    beats_in++;
    window_model(it, outs);
    if (typed) outs = '{want};
    foreach (outs[i]) pending_results.push_back(outs[i]);
  endtask

  // Setup, access, then an idle phase so back-to-back writes never collide.
  task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  // Drain the response side, let the walk settle, then load both registers.
  task automatic set_registers(input logic [TIME_W-1:0] tmo, input logic [RETRY_W-1:0] rl);
    req.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    apb_write(PADDR_W'({REG_TIMEOUT, 2'b00}), tmo);
    timeout_reg = tmo;
    apb_write(PADDR_W'({REG_RETRY, 2'b00}), DATA_W'(rl));
    retry_reg = rl;
  endtask

  function automatic item_t mk(op_e op, logic [SEQ_W-1:0] s, logic [HANDLE_W-1:0] h,
                               logic [KIND_W-1:0] k, logic [TIME_W-1:0] t);
    item_t it;
    it.op = op; it.seq = s; it.handle = h; it.kind = k; it.now = t;
    return it;
  endfunction

  // Mostly in-order traffic near the live window; some noise with wild values.
  function automatic item_t rand_item(bit fill);
    item_t it;
    int    pick;
    pick = fill ? 0 : $urandom_range(0, 99);
    it.handle = HANDLE_W'($urandom);
    it.kind   = KIND_W'($urandom);
    if ($urandom_range(0, 19) == 0) clock_now = $urandom;
    else clock_now = clock_now + $urandom_range(0, 700);
    it.now = clock_now;
    if (pick < 45) begin
      it.op = OP_SEND;
      if ($urandom_range(0, 9) == 0) it.seq = SEQ_W'($urandom);
      else begin
        it.seq = seq_cursor;
        seq_cursor = seq_cursor + 1'b1;
      end
    end else begin
      it.op = (pick < 65) ? OP_ACK : (pick < 80) ? OP_NACK : OP_TICK;
      if ($urandom_range(0, 9) == 0) it.seq = SEQ_W'($urandom);
      else it.seq = seq_cursor - SEQ_W'($urandom_range(1, 12));
    end
    return it;
  endfunction

  // Response side: stall a random number of cycles before each beat.
  initial begin
    int stall;
    rsp.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp.valid);
    end
  end

  // Check every accepted response beat against the oldest expectation.
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && rsp.valid && rsp.ready) begin
      if (pending_results.size() == 0) begin
        report("unexpected beat, result_kind", rsp.result_kind, '0);
      end else begin
        want = pending_results.pop_front();
        if (rsp.result_kind != want.result_kind)
          report("result_kind", rsp.result_kind, want.result_kind);
        if (rsp.entry_seq != want.entry_seq) report("entry_seq", rsp.entry_seq, want.entry_seq);
        if (rsp.entry_handle != want.entry_handle)
          report("entry_handle", rsp.entry_handle, want.entry_handle);
        if (rsp.entry_kind != want.entry_kind)
          report("entry_kind", rsp.entry_kind, want.entry_kind);
        if (rsp.affected_count != want.affected_count)
          report("affected_count", rsp.affected_count, want.affected_count);
        if (rsp.last != want.last) report("last", rsp.last, want.last);
      end
      beats_checked++;
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d beats outstanding", cycles,
               pending_results.size());
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin
    row_t  dir[$];
    res_t  none;
    logic [TIME_W-1:0]  tmo_set [5];
    logic [RETRY_W-1:0] rl_set  [5];

    none = '0;
    req.valid = 1'b0; req.func = '0; req.seq_number = '0; req.buffer_handle = '0;
    req.segment_kind = '0; req.time_now = '0;
    for (int s = 0; s < DEPTH; s++) begin
      w_seq[s] = '0; w_handle[s] = '0; w_kind[s] = '0; w_sent[s] = '0;
      w_retries[s] = '0; w_busy[s] = 1'b0;
    end
    w_base = '0; w_next = '0;
    timeout_reg = TIMEOUT_RST; retry_reg = RETRY_LIMIT_RST;
    seq_cursor = 24'h000100; clock_now = '0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: walks over an empty window, extreme fields, sequence wrap,
    // nack on both sides of the half range, timeouts at the reset limit.
    dir.push_back('{mk(OP_TICK, 24'h0, 16'h0, 8'h0, 32'h0), 1'b1,
                    make_res(RES_SUMMARY, 24'h0, '0, '0, '0, 1'b1)});
    dir.push_back('{mk(OP_ACK, 24'hFFFFFF, 16'hFFFF, 8'hFF, 32'hFFFFFFFF), 1'b1,
                    make_res(RES_SUMMARY, 24'hFFFFFF, '0, '0, '0, 1'b1)});
    dir.push_back('{mk(OP_NACK, 24'h0, 16'h0, 8'h0, 32'h0), 1'b1,
                    make_res(RES_SUMMARY, 24'h0, '0, '0, '0, 1'b1)});
    dir.push_back('{mk(OP_SEND, 24'h0, 16'hFFFF, 8'hFF, 32'h0), 1'b1,
                    make_res(RES_ACCEPTED, 24'h0, 16'hFFFF, 8'hFF, '0, 1'b1)});
    dir.push_back('{mk(OP_SEND, 24'hFFFFFF, 16'h0, 8'h0, 32'hFFFFFFFF), 1'b1,
                    make_res(RES_ACCEPTED, 24'hFFFFFF, 16'h0, 8'h0, '0, 1'b1)});
    dir.push_back('{mk(OP_SEND, 24'h7FFFFF, 16'h1234, 8'h5A, 32'd10), 1'b0, none});
    dir.push_back('{mk(OP_SEND, 24'h800000, 16'hA5A5, 8'h3C, 32'd20), 1'b0, none});
    dir.push_back('{mk(OP_NACK, 24'h0, 16'h0, 8'h0, 32'd30), 1'b0, none});
    dir.push_back('{mk(OP_NACK, 24'h800000, 16'h0, 8'h0, 32'd40), 1'b0, none});
    dir.push_back('{mk(OP_NACK, 24'hFFFFFF, 16'h0, 8'h0, 32'd50), 1'b0, none});
    dir.push_back('{mk(OP_TICK, 24'h0, 16'h0, 8'h0, 32'd500), 1'b0, none});
    dir.push_back('{mk(OP_TICK, 24'h0, 16'h0, 8'h0, 32'd3000), 1'b0, none});
    dir.push_back('{mk(OP_TICK, 24'h0, 16'h0, 8'h0, 32'hFFFFF000), 1'b0, none});
    dir.push_back('{mk(OP_ACK, 24'h0, 16'h0, 8'h0, 32'd0), 1'b0, none});
    dir.push_back('{mk(OP_ACK, 24'h7FFFFF, 16'h0, 8'h0, 32'd0), 1'b0, none});
    dir.push_back('{mk(OP_SEND, 24'h000100, 16'h00FF, 8'h01, 32'd0), 1'b0, none});
    dir.push_back('{mk(OP_ACK, 24'hFFFFFF, 16'h0, 8'h0, 32'd0), 1'b0, none});
    dir.push_back('{mk(OP_ACK, 24'h800000, 16'h0, 8'h0, 32'd0), 1'b0, none});
    foreach (dir[i]) push_item(dir[i].it, dir[i].typed, dir[i].want);

    // Phases of random traffic, each under one register setting; the drain
    // before each write is the sender pause that lets every beat come back.
    tmo_set = '{32'd1000, 32'd0, 32'hFFFFFFFF, 32'd1, 32'd0};
    rl_set  = '{8'd0, 8'd0, 8'd255, 8'd1, 8'd0};
    tmo_set[4] = $urandom_range(1, 3000);
    rl_set[4]  = RETRY_W'($urandom_range(0, 8));
    for (int ph = 0; ph < 5; ph++) begin
      set_registers(tmo_set[ph], rl_set[ph]);
      calm = (ph == 2);
      for (int n = 0; n < PHASE_LEN; n++) begin
        // now and then stuff the window past full
        if ($urandom_range(0, 49) == 0) begin
          for (int f = 0; f < DEPTH + 2; f++) push_item(rand_item(1'b1), 1'b0, none);
        end
        push_item(rand_item(1'b0), 1'b0, none);
      end
    end
    req.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("covered %0d request beats and %0d response beats over five register settings",
             beats_in, beats_checked);
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
